// File: design/dmar_pkg.sv
// Shared types and constants for the DMA descriptor ring.
`timescale 1ns / 1ps
package dmar_pkg;

	localparam int RING_DEPTH = 256;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int OCC_W      = $clog2(RING_DEPTH + 1);

	localparam logic FUNC_SUBMIT   = 1'b0;
	localparam logic FUNC_COMPLETE = 1'b1;

	typedef enum logic [1:0] {
		RES_OK    = 2'd0,
		RES_FULL  = 2'd1,
		RES_EMPTY = 2'd2
	} res_code_t;

	typedef struct packed {
		logic [63:0] address;
		logic [31:0] length;
		logic [31:0] flags;
		logic [63:0] stamp;
	} slot_t;

	typedef struct packed {
		res_code_t   code;
		logic        pop;
		logic [8:0]  used;
		logic [8:0]  free;
		logic [63:0] submit_total;
		logic [63:0] complete_total;
		logic [63:0] overrun_total;
		logic [63:0] time_now;
	} stage_t;

endpackage

// File: design/dmar_ctrl.sv
// Ring pointers, occupancy, statistics counters and the first stage register.
`timescale 1ns / 1ps
module dmar_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      en_s1,
	input  logic                      func,
	input  logic [63:0]               time_now,
	output logic [dmar_pkg::IDX_W-1:0] head_idx,
	output logic [dmar_pkg::IDX_W-1:0] tail_idx,
	output logic                      slot_wr,
	output logic                      status_wr,
	output logic                      valid_s1,
	output dmar_pkg::stage_t          stage_s1
);

	localparam logic [dmar_pkg::IDX_W-1:0] LAST_IDX = dmar_pkg::IDX_W'(dmar_pkg::RING_DEPTH - 1);
	localparam logic [dmar_pkg::OCC_W-1:0] FULL_OCC = dmar_pkg::OCC_W'(dmar_pkg::RING_DEPTH);

	logic [dmar_pkg::IDX_W-1:0] head_q, tail_q;
	logic [dmar_pkg::OCC_W-1:0] occ_q, occ_next;
	logic [63:0]                submits_q, completes_q, overruns_q;
	logic [63:0]                submits_next, completes_next, overruns_next;
	logic                       push, pop, overrun;
	dmar_pkg::res_code_t        code;

	always_comb begin
		code    = dmar_pkg::RES_OK;
		push    = 1'b0;
		pop     = 1'b0;
		overrun = 1'b0;
		unique case (func)
			dmar_pkg::FUNC_SUBMIT: begin
				if (occ_q == FULL_OCC) begin
					code    = dmar_pkg::RES_FULL;
					overrun = 1'b1;
				end else begin
					push = 1'b1;
				end
			end
			dmar_pkg::FUNC_COMPLETE: begin
				if (occ_q == '0) begin
					code = dmar_pkg::RES_EMPTY;
				end else begin
					pop = 1'b1;
				end
			end
		endcase
	end

	assign occ_next       = occ_q + dmar_pkg::OCC_W'(push) - dmar_pkg::OCC_W'(pop);
	assign submits_next   = submits_q + 64'(push);
	assign completes_next = completes_q + 64'(pop);
	assign overruns_next  = overruns_q + 64'(overrun);

	assign head_idx  = head_q;
	assign tail_idx  = tail_q;
	assign slot_wr   = accept && push;
	assign status_wr = accept && pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			submits_q   <= '0;
			completes_q <= '0;
			overruns_q  <= '0;
		end else if (accept) begin
			if (push) begin
				head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
			end
			if (pop) begin
				tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
			end
			occ_q       <= occ_next;
			submits_q   <= submits_next;
			completes_q <= completes_next;
			overruns_q  <= overruns_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.code           <= code;
			stage_s1.pop            <= pop;
			stage_s1.used           <= 9'(occ_next);
			stage_s1.free           <= 9'(FULL_OCC - occ_next);
			stage_s1.submit_total   <= submits_next;
			stage_s1.complete_total <= completes_next;
			stage_s1.overrun_total  <= overruns_next;
			stage_s1.time_now       <= time_now;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FULL_OCC)
		else $error("occupancy exceeds ring depth");

	a_ptr_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q != tail_q) |-> (occ_q != '0 && occ_q != FULL_OCC))
		else $error("pointers apart while ring empty or full");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == dmar_pkg::FUNC_COMPLETE && occ_q != '0)
			|=> (occ_q == $past(occ_q) - 1'b1))
		else $error("good complete did not reduce occupancy");

endmodule

// File: design/dmar_slot_mem.sv
// Descriptor slot storage with one write port and a registered tail read.
`timescale 1ns / 1ps
module dmar_slot_mem (
	input  logic                       clk,
	input  logic                       slot_wr,
	input  logic                       status_wr,
	input  logic [dmar_pkg::IDX_W-1:0] head_idx,
	input  logic [dmar_pkg::IDX_W-1:0] tail_idx,
	input  dmar_pkg::slot_t            slot_data,
	input  logic [31:0]                done_status,
	input  logic                       rd_en,
	output logic [31:0]                rd_length,
	output logic [63:0]                rd_stamp
);

	dmar_pkg::slot_t slot_mem   [dmar_pkg::RING_DEPTH];
	logic [31:0]     status_mem [dmar_pkg::RING_DEPTH];

	always_ff @(posedge clk) begin
		if (slot_wr) begin
			slot_mem[head_idx] <= slot_data;
		end
	end

	// A submit leaves the status pending (zero); a complete writes its status.
	always_ff @(posedge clk) begin
		if (slot_wr) begin
			status_mem[head_idx] <= '0;
		end else if (status_wr) begin
			status_mem[tail_idx] <= done_status;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_length <= slot_mem[tail_idx].length;
			rd_stamp  <= slot_mem[tail_idx].stamp;
		end
	end

endmodule

// File: design/dmar_result.sv
// Latency computation and the output register of the result channel.
`timescale 1ns / 1ps
module dmar_result (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  dmar_pkg::stage_t stage_s1,
	input  logic [31:0]      rd_length,
	input  logic [63:0]      rd_stamp,
	input  logic             out_stall,
	output logic             en_out,
	output logic             out_valid,
	output logic [1:0]       result_code,
	output logic [31:0]      done_length,
	output logic [63:0]      latency,
	output logic [8:0]       used_entries,
	output logic [8:0]       free_entries,
	output logic [63:0]      submit_total,
	output logic [63:0]      complete_total,
	output logic [63:0]      overrun_total
);

	logic valid_q;

	assign en_out    = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en_out) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s1) begin
			result_code    <= stage_s1.code;
			done_length    <= stage_s1.pop ? rd_length : '0;
			latency        <= stage_s1.pop ? (stage_s1.time_now - rd_stamp) : '0;
			used_entries   <= stage_s1.used;
			free_entries   <= stage_s1.free;
			submit_total   <= stage_s1.submit_total;
			complete_total <= stage_s1.complete_total;
			overrun_total  <= stage_s1.overrun_total;
		end
	end

endmodule

// File: design/dma_descriptor_ring.sv
// Top level of the DMA descriptor ring: submit and complete items over a slot memory.
// The result of an accepted item is registered in stage one and then in the output register.
// One item is accepted per cycle while in_stall is low; the pointer and occupancy update
// is a single increment and the tail slot read is one registered memory port.
// Reset clears the pointers, occupancy, the three statistics counters and all valid flags.
// Slot storage is not initialized; a slot's read data is used only after a submit has filled it.
`timescale 1ns / 1ps
module dma_descriptor_ring (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [63:0] buf_address,
	input  logic [31:0] xfer_length,
	input  logic [31:0] desc_flags,
	input  logic [31:0] done_status,
	input  logic [63:0] time_now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_code,
	output logic [31:0] done_length,
	output logic [63:0] latency,
	output logic [8:0]  used_entries,
	output logic [8:0]  free_entries,
	output logic [63:0] submit_total,
	output logic [63:0] complete_total,
	output logic [63:0] overrun_total
);

	logic                       accept;
	logic                       en_s1;
	logic                       en_out;
	logic                       valid_s1;
	logic                       slot_wr;
	logic                       status_wr;
	logic [dmar_pkg::IDX_W-1:0] head_idx;
	logic [dmar_pkg::IDX_W-1:0] tail_idx;
	logic [31:0]                rd_length;
	logic [63:0]                rd_stamp;
	dmar_pkg::stage_t           stage_s1;
	dmar_pkg::slot_t            slot_data;

	// The first stage moves whenever it is empty or the output register can take its item,
	// so a new item is still taken while a finished result waits, as long as stage one is free.
	assign en_s1    = !valid_s1 || en_out;
	assign in_stall = !en_s1;
	assign accept   = in_valid && en_s1;

	assign slot_data.address = buf_address;
	assign slot_data.length  = xfer_length;
	assign slot_data.flags   = desc_flags;
	assign slot_data.stamp   = time_now;

	// All ring decisions are made at accept time against the live pointers, so
	// back-to-back items always see the state left by the item before them.
	dmar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.en_s1     (en_s1),
		.func      (func),
		.time_now  (time_now),
		.head_idx  (head_idx),
		.tail_idx  (tail_idx),
		.slot_wr   (slot_wr),
		.status_wr (status_wr),
		.valid_s1  (valid_s1),
		.stage_s1  (stage_s1)
	);

	// The tail slot is read on the same edge that registers the item. A slot written by
	// the previous item is already in memory by then, and the read data is used only by a
	// complete, which writes only the status memory and never the slot that it reads.
	dmar_slot_mem u_slot_mem (
		.clk         (clk),
		.slot_wr     (slot_wr),
		.status_wr   (status_wr),
		.head_idx    (head_idx),
		.tail_idx    (tail_idx),
		.slot_data   (slot_data),
		.done_status (done_status),
		.rd_en       (en_s1),
		.rd_length   (rd_length),
		.rd_stamp    (rd_stamp)
	);

	// The latency subtraction sits between stage one and the output register.
	dmar_result u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.stage_s1       (stage_s1),
		.rd_length      (rd_length),
		.rd_stamp       (rd_stamp),
		.out_stall      (out_stall),
		.en_out         (en_out),
		.out_valid      (out_valid),
		.result_code    (result_code),
		.done_length    (done_length),
		.latency        (latency),
		.used_entries   (used_entries),
		.free_entries   (free_entries),
		.submit_total   (submit_total),
		.complete_total (complete_total),
		.overrun_total  (overrun_total)
	);

endmodule
